// ===== hw/rtl/mrpt_pkg.sv =====
// Package: shared constants, types and witness table for the primality tester.
package mrpt_pkg;
    localparam int VALUE_BITS_DEF    = 64;
    localparam int WITNESS_COUNT_DEF = 12;
    localparam int NUM_BASES         = 12;
    localparam int WITNESS_BITS      = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_WIT,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_TEST,
        ST_SQR,
        ST_SQR_TEST,
        ST_DONE
    } mr_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } mm_ctrl_t;

    function automatic logic [WITNESS_BITS-1:0] witness(input logic [3:0] idx);
        logic [WITNESS_BITS-1:0] w;
        begin
            unique case (idx)
                4'd0:    w = 6'd2;
                4'd1:    w = 6'd3;
                4'd2:    w = 6'd5;
                4'd3:    w = 6'd7;
                4'd4:    w = 6'd11;
                4'd5:    w = 6'd13;
                4'd6:    w = 6'd17;
                4'd7:    w = 6'd19;
                4'd8:    w = 6'd23;
                4'd9:    w = 6'd29;
                4'd10:   w = 6'd31;
                4'd11:   w = 6'd37;
                default: w = 6'd37;
            endcase
            return w;
        end
    endfunction
endpackage

// ===== hw/rtl/miller_rabin_primality_test.sv =====
// Top level: deterministic Miller-Rabin primality tester with one serial multiplier.
//
// Input channel: candidate with in_valid/in_stall; a transaction is taken when
// in_valid is high and in_stall is low. Only the low VALUE_BITS bits are used.
// Output channel: tested_value and is_prime with out_valid/out_stall; one
// result per candidate, held stable while out_stall is high.
// One candidate is in flight at a time; in_stall is high from acceptance
// until its result is taken.
// Trivial cases (below 2, two, three, even) finish without the multiplier.
// Otherwise n-1 is split, then per witness each modular multiply runs on the
// shared bit-serial multiplier; the exponent bits and the r-1 squarings together
// stay below VALUE_BITS, so a witness needs up to about 2*VALUE_BITS multiplies.
// Reset empties the block; out_valid drops and the input is open.
module miller_rabin_primality_test
    import mrpt_pkg::*;
#(
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int WITNESS_COUNT = WITNESS_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           candidate,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [63:0]           tested_value,
    output logic                  is_prime
);
    localparam int RB = $clog2(VALUE_BITS + 1);
    localparam int WC = (WITNESS_COUNT > NUM_BASES) ? NUM_BASES : WITNESS_COUNT;

    mr_state_t             state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg, d_reg, e_reg, base_reg, x_reg;
    logic [RB-1:0]         r_reg, j_reg;
    logic [3:0]            wi_reg;
    logic                  prime_reg, out_valid_reg, pend_reg;
    logic                  mm_start;
    logic [VALUE_BITS-1:0] mm_a, mm_b, mm_p;
    mm_ctrl_t              mm_ctrl;
    logic [VALUE_BITS-1:0] nm1;
    logic [VALUE_BITS-1:0] wval;

    assign nm1  = n_reg - 1'b1;
    assign wval = VALUE_BITS'(witness(wi_reg));

    mrpt_modmul #(.VALUE_BITS(VALUE_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mm_start),
        .a(mm_a), .b(mm_b), .m(n_reg), .ctrl(mm_ctrl), .product(mm_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= mm_start ? 1'b1 : (mm_ctrl.done ? 1'b0 : pend_reg);
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mm_start   = 1'b0;
        mm_a       = x_reg;
        mm_b       = base_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !out_valid_reg)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (n_reg < VALUE_BITS'(4) || !n_reg[0])
                    state_next = ST_DONE;
                else
                    state_next = ST_SPLIT;
            ST_SPLIT:
                if (d_reg[0])
                    state_next = ST_WIT;
            ST_WIT:
                if (wi_reg == 4'(WC) || wval >= n_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_POW_MUL;
            ST_POW_MUL:
            begin
                if (e_reg == '0)
                    state_next = ST_TEST;
                else if (!e_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = base_reg;
                    state_next = ST_POW_SQR;
                end
                else if (!pend_reg && !mm_ctrl.done)
                    mm_start = 1'b1;
                else if (mm_ctrl.done)
                begin
                    mm_start   = 1'b1;
                    mm_a       = base_reg;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
                if (mm_ctrl.done)
                    state_next = ST_POW_MUL;
            ST_TEST:
                if (x_reg == VALUE_BITS'(1) || x_reg == nm1)
                    state_next = ST_WIT;
                else if (j_reg >= r_reg)
                    state_next = ST_DONE;
                else
                begin
                    mm_start   = 1'b1;
                    mm_b       = x_reg;
                    state_next = ST_SQR;
                end
            ST_SQR:
            begin
                mm_b = x_reg;
                if (mm_ctrl.done)
                    state_next = ST_SQR_TEST;
            end
            ST_SQR_TEST:
                if (x_reg == nm1)
                    state_next = ST_WIT;
                else if (j_reg >= r_reg)
                    state_next = ST_DONE;
                else
                begin
                    mm_start   = 1'b1;
                    mm_b       = x_reg;
                    state_next = ST_SQR;
                end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !out_valid_reg)
                begin
                    n_reg <= candidate[VALUE_BITS-1:0];
                    d_reg <= candidate[VALUE_BITS-1:0] - 1'b1;
                    r_reg <= '0;
                    wi_reg <= '0;
                end
            ST_CHECK:
                prime_reg <= (n_reg == VALUE_BITS'(2)) || (n_reg == VALUE_BITS'(3))
                             || (n_reg >= VALUE_BITS'(4) && n_reg[0]);
            ST_SPLIT:
                if (!d_reg[0])
                begin
                    d_reg <= d_reg >> 1;
                    r_reg <= r_reg + 1'b1;
                end
            ST_WIT:
            begin
                base_reg <= wval;
                e_reg    <= d_reg;
                x_reg    <= VALUE_BITS'(1);
                j_reg    <= RB'(1);
                wi_reg   <= wi_reg + 1'b1;
            end
            ST_POW_MUL:
                if (mm_ctrl.done && e_reg[0])
                    x_reg <= mm_p;
            ST_POW_SQR:
                if (mm_ctrl.done)
                begin
                    base_reg <= mm_p;
                    e_reg    <= e_reg >> 1;
                end
            ST_TEST:
                if (!(x_reg == VALUE_BITS'(1) || x_reg == nm1) && j_reg >= r_reg)
                    prime_reg <= 1'b0;
            ST_SQR:
                if (mm_ctrl.done)
                begin
                    x_reg <= mm_p;
                    j_reg <= j_reg + 1'b1;
                end
            ST_SQR_TEST:
                if (x_reg != nm1 && j_reg >= r_reg)
                    prime_reg <= 1'b0;
            default:
                ;
        endcase
    end

    assign in_stall     = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign tested_value = 64'(n_reg);
    assign is_prime     = prime_reg;
endmodule

// ===== hw/rtl/mrpt_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, double-and-add mod m.
module mrpt_modmul
    import mrpt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    input  logic [VALUE_BITS-1:0] m,
    output mm_ctrl_t              ctrl,
    output logic [VALUE_BITS-1:0] product
);
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] a_reg, b_reg, m_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg, done_reg;
    logic [VALUE_BITS:0]   dbl, dbl_red, sum;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = dbl_red;
        if (b_reg[VALUE_BITS-1])
        begin
            sum = dbl_red + {1'b0, a_reg};
            if (sum >= {1'b0, m_reg})
                sum = sum - {1'b0, m_reg};
        end
        acc_next = sum[VALUE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[VALUE_BITS-2:0], 1'b0};
        end
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
    assign product    = acc_reg;
endmodule

// ===== hw/rtl/mrpt_checker.sv =====
// Checker: port-level assertions for the primality tester, bound to the top level.
module mrpt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [63:0] candidate,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] tested_value,
    input logic        is_prime
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tested_value) && $stable(is_prime))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(candidate))
        else $error("candidate changed while stalled");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transaction");

    a_out_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result waits");

    a_small: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tested_value == 64'd0 || tested_value == 64'd1) |-> !is_prime)
        else $error("value below two reported prime");
endmodule

bind miller_rabin_primality_test mrpt_checker u_mrpt_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .out_valid(out_valid), .out_stall(out_stall),
    .tested_value(tested_value), .is_prime(is_prime)
);

// ===== sim/miller_rabin_primality_test_test.sv =====
// Testbench for the Miller-Rabin primality tester: random and directed candidates checked against a local predictor.
module miller_rabin_primality_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS    = 64;
    localparam int WITNESS_COUNT = 12;
    localparam int BASE_TABLE_LEN = 12;

    typedef struct {
        logic [63:0] value;
        logic        prime;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] candidate;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] tested_value;
    logic        is_prime;

    logic [63:0] pending_candidates[$];
    verdict_t    expected_verdicts[$];
    int          error_count;
    bit          stimulus_done;
    int          cycle_count;
    int          hold_off_left;

    miller_rabin_primality_test #(
        .VALUE_BITS   (VALUE_BITS),
        .WITNESS_COUNT(WITNESS_COUNT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tested_value(tested_value),
        .is_prime    (is_prime)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            return 64'(p % {64'd0, m});
        end
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] b;
        begin
            acc = 64'd1 % m;
            b = base % m;
            while (e != 0)
            begin
                if (e[0])
                    acc = mulmod(acc, b, m);
                b = mulmod(b, b, m);
                e = e >> 1;
            end
            return acc;
        end
    endfunction

    function automatic logic is_prime_value(logic [63:0] n);
        logic [63:0] witnesses[BASE_TABLE_LEN];
        logic [63:0] d;
        logic [63:0] x;
        int          r;
        bit          passed;
        begin
            witnesses = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                          64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};
            if (n < 2)
                return 1'b0;
            if (n == 2 || n == 3)
                return 1'b1;
            if (!n[0])
                return 1'b0;
            d = n - 1;
            r = 0;
            while (!d[0])
            begin
                d = d >> 1;
                r++;
            end
            for (int i = 0; i < WITNESS_COUNT && witnesses[i] < n; i++)
            begin
                x = powmod(witnesses[i], d, n);
                if (x == 1 || x == n - 1)
                    continue;
                passed = 0;
                for (int j = 1; j < r; j++)
                begin
                    x = mulmod(x, x, n);
                    if (x == n - 1)
                    begin
                        passed = 1;
                        break;
                    end
                end
                if (!passed)
                    return 1'b0;
            end
            return 1'b1;
        end
    endfunction

    function automatic logic [63:0] random_odd_candidate();
        logic [63:0] v;
        int          bits;
        begin
            bits = $urandom_range(64, 2);
            v = {$urandom, $urandom};
            if (bits < 64)
                v = v & ((64'd1 << bits) - 1);
            return v | 64'd1;
        end
    endfunction

    initial
    begin
        logic [63:0] v;
        int          pick;
        pending_candidates.push_back(64'd0);
        pending_candidates.push_back(64'd1);
        pending_candidates.push_back(64'd2);
        pending_candidates.push_back(64'd3);
        pending_candidates.push_back(64'd4);
        pending_candidates.push_back(64'd9);
        pending_candidates.push_back(64'd37);
        pending_candidates.push_back(64'd41);
        pending_candidates.push_back(64'd2047);
        pending_candidates.push_back(64'd3215031751);
        pending_candidates.push_back(64'd3825123056546413051);
        pending_candidates.push_back(64'd341550071728321);
        pending_candidates.push_back(64'hFFFF_FFFF_FFFF_FFC5);
        pending_candidates.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_candidates.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        pending_candidates.push_back(64'h8000_0000_0000_0000);
        pending_candidates.push_back(64'h8000_0000_0000_0001);
        pending_candidates.push_back(64'd4294967291);
        pending_candidates.push_back(64'd4294967297);
        pending_candidates.push_back(64'h5555_5555_5555_5555);
        pending_candidates.push_back(64'hAAAA_AAAA_AAAA_AAAB);
        for (int i = 0; i < 80; i++)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 6)
                v = random_odd_candidate();
            else if (pick < 8)
                v = 64'($urandom_range(200, 0));
            else
                v = {$urandom, $urandom};
            pending_candidates.push_back(v);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        stimulus_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            candidate <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_verdicts.push_back('{candidate, is_prime_value(candidate)});
                void'(pending_candidates.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (in_valid && !in_stall && pending_candidates.size() == 0)
                begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1;
                end
                else if (pending_candidates.size() != 0
                         && (cycle_count < 30000 || $urandom_range(99, 0) >= 13))
                begin
                    in_valid  <= 1'b1;
                    candidate <= pending_candidates[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_off_left <= 0;
        else if (cycle_count == 200)
            hold_off_left <= 3000;
        else if (hold_off_left > 0)
            hold_off_left <= hold_off_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result tested_value=%h", tested_value);
                    error_count = error_count + 1;
                end
                else
                begin
                    if (tested_value !== expected_verdicts[0].value)
                    begin
                        $error("tested_value expected %h actual %h",
                               expected_verdicts[0].value, tested_value);
                        error_count = error_count + 1;
                    end
                    if (is_prime !== expected_verdicts[0].prime)
                    begin
                        $error("is_prime expected %b actual %b for %h",
                               expected_verdicts[0].prime, is_prime, tested_value);
                        error_count = error_count + 1;
                    end
                    void'(expected_verdicts.pop_front());
                end
            end
            out_stall <= (hold_off_left > 1)
                         || ((cycle_count >= 30000) && ($urandom_range(99, 0) < 13));
        end
    end

    initial
    begin
        wait (rst_n);
        wait (stimulus_done && expected_verdicts.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("miller_rabin_primality_test_test: PASS");
        else
            $display("miller_rabin_primality_test_test: FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("miller_rabin_primality_test_test: FAIL");
        $finish;
    end
endmodule
